### hdl/wsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared types, character codes and helpers of the wildcard string matcher.
// ----------------------------------------------------------------------------
package wsm_pkg;

    localparam int CHAR_W    = 8;
    localparam int WORD_W    = 64;
    localparam int WORDS     = 4;
    localparam int PAT_W     = WORD_W * WORDS;
    localparam int LEN_W     = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
    localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;
    localparam logic [CHAR_W-1:0] UPPER_A   = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] LOWER_A   = 8'h61;
    localparam logic [CHAR_W-1:0] NO_CHAR   = 8'h00;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH   = 3'd0,
        REG_BYTES_LOW        = 3'd1,
        REG_BYTES_SECOND     = 3'd2,
        REG_BYTES_THIRD      = 3'd3,
        REG_BYTES_HIGH       = 3'd4,
        REG_CASE_INSENSITIVE = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pattern;
        logic             fold_case;
    } t_cfg;

    // ascii upper to lower when folding is on
    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c,
                                               input logic            on);
        if (on && c >= UPPER_A && c <= UPPER_Z) begin
            return c - UPPER_A + LOWER_A;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### hdl/wsm_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsm channel interfaces
// Valid/ready channels for source words, match results and configuration.
// ----------------------------------------------------------------------------
interface wsm_in_if;
    logic                       valid;
    logic                       ready;
    logic [wsm_pkg::CHAR_W-1:0] source_char;
    logic                       last;

    modport source (output valid, output source_char, output last, input ready);
    modport sink   (input valid, input source_char, input last, output ready);
endinterface

interface wsm_out_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

interface wsm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [wsm_pkg::CFG_IDX_W-1:0] index;
    logic [wsm_pkg::WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hdl/wsm_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsm_cfg_regs
// Configuration register file: pattern length, pattern bytes, case folding.
// ----------------------------------------------------------------------------
module wsm_cfg_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    wsm_cfg_if.sink          i_cfg,
    output wsm_pkg::t_cfg    o_cfg
);

    logic [wsm_pkg::LEN_W-1:0]  r_len;
    logic [wsm_pkg::WORD_W-1:0] r_words [wsm_pkg::WORDS];
    logic                       r_fold_case;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_words[0]  <= '0;
            r_words[1]  <= '0;
            r_words[2]  <= '0;
            r_words[3]  <= '0;
            r_fold_case <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (wsm_pkg::t_reg_idx'(i_cfg.index))
                wsm_pkg::REG_PATTERN_LENGTH:   r_len <= i_cfg.data[wsm_pkg::LEN_W-1:0];
                wsm_pkg::REG_BYTES_LOW:        r_words[0] <= i_cfg.data;
                wsm_pkg::REG_BYTES_SECOND:     r_words[1] <= i_cfg.data;
                wsm_pkg::REG_BYTES_THIRD:      r_words[2] <= i_cfg.data;
                wsm_pkg::REG_BYTES_HIGH:       r_words[3] <= i_cfg.data;
                wsm_pkg::REG_CASE_INSENSITIVE: r_fold_case <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg.len       = r_len;
    assign o_cfg.pattern   = {r_words[3], r_words[2], r_words[1], r_words[0]};
    assign o_cfg.fold_case = r_fold_case;

endmodule
`default_nettype wire

### hdl/wsm_nfa.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsm_nfa
// Active pattern position vector and its one-word update with star closure.
// ----------------------------------------------------------------------------
module wsm_nfa #(
    parameter int PATTERN_MAX = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [wsm_pkg::CHAR_W-1:0] i_char,
    input  wire logic                       i_last,
    input  wire wsm_pkg::t_cfg              i_cfg,
    output logic                            o_matched
);

    localparam int W    = PATTERN_MAX + 1;
    localparam int LW   = $clog2(W);
    localparam int LenW = wsm_pkg::LEN_W;

    logic [W-1:0]                r_active;
    logic [W-1:0]                n_active;
    logic [LW-1:0]               len;
    logic [W-1:0]                mask;
    logic [W-1:0]                prop;
    logic [W-1:0]                star_v;
    logic [W-1:0]                hit_v;
    logic [W-1:0]                s0;
    logic [W-1:0]                nxt;
    logic [W-1:0]                s1;
    logic [wsm_pkg::CHAR_W-1:0]  fc;
    logic [wsm_pkg::CHAR_W-1:0]  pc;
    logic                        in_use;

    // prefix closure: a set bit runs up through consecutive stars
    function automatic logic [W-1:0] close_stars(input logic [W-1:0] g_in,
                                                 input logic [W-1:0] p_in);
        logic [W-1:0] g;
        logic [W-1:0] p;
        g = g_in;
        p = p_in;
        for (int d = 1; d < W; d = d * 2) begin
            g = g | (p & (g << d));
            p = p & (p << d);
        end
        return g;
    endfunction

    always_comb begin
        len = (i_cfg.len > LenW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : LW'(i_cfg.len);
        fc  = wsm_pkg::fold(i_char, i_cfg.fold_case);
        pc  = '0;
        in_use = 1'b0;
        for (int i = 0; i < W; i++) begin
            mask[i]   = (LW'(i) <= len);
            star_v[i] = 1'b0;
            hit_v[i]  = 1'b0;
            prop[i]   = 1'b0;
        end
        for (int i = 0; i < PATTERN_MAX; i++) begin
            pc        = i_cfg.pattern[i*wsm_pkg::CHAR_W +: wsm_pkg::CHAR_W];
            in_use    = (LW'(i) < len);
            star_v[i] = in_use && (pc == wsm_pkg::STAR_CHAR);
            hit_v[i]  = in_use && (pc != wsm_pkg::STAR_CHAR)
                        && ((pc == wsm_pkg::ANY_CHAR)
                            || (wsm_pkg::fold(pc, i_cfg.fold_case) == fc));
            prop[i+1] = star_v[i];
        end
        s0  = close_stars(r_active & mask, prop);
        // a star keeps its position, a matching char advances one
        nxt = (s0 & star_v) | ((s0 & hit_v) << 1);
        s1  = (i_char != wsm_pkg::NO_CHAR) ? close_stars(nxt, prop) : s0;
        o_matched = s1[len];
        n_active  = i_last ? W'(1) : s1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= W'(1);
        end else if (i_step) begin
            r_active <= n_active;
        end
    end

endmodule
`default_nettype wire

### hdl/wildcard_string_matcher_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_string_matcher_top
// Streams a source string one byte per word and checks it against a glob.
// ----------------------------------------------------------------------------
// usage
//   i_cfg : register writes (index, data), always ready; write while idle
//           0 length, 1..4 pattern bytes (8 per register), 5 case folding
//   i_in  : one source byte per word, last marks the end of the string;
//           a zero byte consumes nothing (used to end an empty string)
//   o_out : one matched word per string, sent for the word with last set
// timing
//   a word is accepted every cycle unless a held result blocks a last word;
//   it sits in the input register while the position vector is updated,
//   and matched is then registered in the result register
//   the update of the position vector sets the rate
// reset
//   pattern empty, folding off, only position zero active, no result held
// stall
//   a held result blocks only a following last word; other words keep
//   flowing into the position vector
// ----------------------------------------------------------------------------
module wildcard_string_matcher_top #(
    parameter int PATTERN_MAX = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wsm_cfg_if.sink   i_cfg,
    wsm_in_if.sink    i_in,
    wsm_out_if.source o_out
);

    wsm_pkg::t_cfg              cfg;

    // input register
    logic                       r_in_valid;
    logic [wsm_pkg::CHAR_W-1:0] r_char;
    logic                       r_last;

    // result register
    logic                       r_out_valid;
    logic                       r_matched;

    logic                       advance;
    logic                       matched;

    wsm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // a last word needs a free result slot, other words always move on
    assign advance    = r_in_valid && (!r_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    wsm_nfa #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_nfa (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_char    (r_char),
        .i_last    (r_last),
        .i_cfg     (cfg),
        .o_matched (matched)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance && r_last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_char <= i_in.source_char;
            r_last <= i_in.last;
        end
        if (advance && r_last) begin
            r_matched <= matched;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.matched = r_matched;

endmodule
`default_nettype wire

### tb/wsm_match_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsm_match_checker
// Watches the register, source and result channels of the wildcard string
// matcher, tracks the active pattern positions per string and checks every
// matched word against the predicted outcome.
// ----------------------------------------------------------------------------
module wsm_match_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wsm_cfg_if        i_cfg,
    wsm_in_if         i_in,
    wsm_out_if        i_out,
    output int        o_fail_count,
    output int        o_pending
);
    import wsm_pkg::*;

    localparam int PATTERN_MAX = 32;
    localparam int POS_W       = PATTERN_MAX + 1;

    logic [LEN_W-1:0] len_reg;
    logic [PAT_W-1:0] pattern_reg;
    logic             fold_reg;
    logic [POS_W-1:0] positions;
    logic             expected_matches[$];
    int               fails;

    function automatic int used_length();
        return (int'(len_reg) > PATTERN_MAX) ? PATTERN_MAX : int'(len_reg);
    endfunction

    function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
        if (fold_reg && c >= UPPER_A && c <= UPPER_Z) begin
            return c + (LOWER_A - UPPER_A);
        end
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] pattern_char(input int i);
        return pattern_reg[i*CHAR_W +: CHAR_W];
    endfunction

    // a live star position also makes the position after it live
    function automatic logic [POS_W-1:0] close_stars(input logic [POS_W-1:0] s,
                                                     input int n);
        logic [POS_W-1:0] r;
        r = s;
        for (int i = 0; i < n; i++) begin
            if (r[i] && pattern_char(i) == STAR_CHAR) begin
                r[i+1] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] advance_positions(input logic [CHAR_W-1:0] c);
        int               n;
        logic [POS_W-1:0] s;
        logic [POS_W-1:0] nxt;
        logic [CHAR_W-1:0] p;
        n = used_length();
        s = '0;
        for (int i = 0; i <= n; i++) begin
            s[i] = positions[i];
        end
        s = close_stars(s, n);
        if (c != NO_CHAR) begin
            nxt = '0;
            for (int i = 0; i < n; i++) begin
                if (s[i]) begin
                    p = pattern_char(i);
                    if (p == STAR_CHAR) begin
                        nxt[i] = 1'b1;
                    end else if (p == ANY_CHAR || to_lower(p) == to_lower(c)) begin
                        nxt[i+1] = 1'b1;
                    end
                end
            end
            s = close_stars(nxt, n);
        end
        return s;
    endfunction

    always @(posedge i_clk) begin
        logic [POS_W-1:0] next_pos;
        logic             want;
        if (!i_rst_n) begin
            len_reg     = '0;
            pattern_reg = '0;
            fold_reg    = 1'b0;
            positions   = POS_W'(1);
            fails       = 0;
            expected_matches.delete();
        end else begin
            // source word first, a register write only counts from the next word
            if (i_in.valid && i_in.ready) begin
                next_pos = advance_positions(i_in.source_char);
                if (i_in.last) begin
                    expected_matches.push_back(next_pos[used_length()]);
                    positions = POS_W'(1);
                end else begin
                    positions = next_pos;
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_PATTERN_LENGTH:   len_reg = i_cfg.data[LEN_W-1:0];
                    REG_BYTES_LOW:        pattern_reg[0*WORD_W +: WORD_W] = i_cfg.data;
                    REG_BYTES_SECOND:     pattern_reg[1*WORD_W +: WORD_W] = i_cfg.data;
                    REG_BYTES_THIRD:      pattern_reg[2*WORD_W +: WORD_W] = i_cfg.data;
                    REG_BYTES_HIGH:       pattern_reg[3*WORD_W +: WORD_W] = i_cfg.data;
                    REG_CASE_INSENSITIVE: fold_reg = i_cfg.data[0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_matches.size() == 0) begin
                    $display("%0t unexpected matched word: expected none, actual %0b",
                             $time, i_out.matched);
                    fails++;
                end else begin
                    want = expected_matches.pop_front();
                    if (i_out.matched !== want) begin
                        $display("%0t matched mismatch: expected %0b, actual %0b",
                                 $time, want, i_out.matched);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_matches.size();
    end

endmodule
`default_nettype wire

### tb/tb_wildcard_string_matcher_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_wildcard_string_matcher_top
// Drives patterns and source strings into the wildcard string matcher with
// random gaps and result stalls; a side checker predicts every matched word.
// ----------------------------------------------------------------------------
module tb_wildcard_string_matcher_top;
    import wsm_pkg::*;

    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 3;
    localparam int SETTLE_CYCLES    = 4;     // spare cycles after the last matched word
    localparam int STALL_LIMIT      = 1000;  // cycles with no word accepted anywhere
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int RANDOM_WORDS     = 1650;
    localparam int STRINGS_PER_SET  = 12;

    // register indexes past the list, the block must ignore them
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    localparam logic [CHAR_W-1:0] LOWER_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

    typedef logic [CHAR_W-1:0] t_bytes[$];

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    wsm_cfg_if cfg_ch ();
    wsm_in_if  src_ch ();
    wsm_out_if res_ch ();

    int fail_count;
    int pending;

    // stimulus side copy of the loaded pattern, used to build strings that match
    logic [PAT_W-1:0] cur_pattern;
    int               cur_len;
    logic             cur_fold;

    // idling controls shared with the result side
    logic no_gaps         = 1'b0;
    int   long_holds_asked = 0;
    int   long_holds_done  = 0;

    wildcard_string_matcher_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (src_ch),
        .o_out   (res_ch)
    );

    wsm_match_checker u_match_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_ch),
        .i_in         (src_ch),
        .i_out        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // character helpers
    // ------------------------------------------------------------------------

    // a few letters in both cases plus the two wildcards
    function automatic logic [CHAR_W-1:0] sample_char(input int k);
        case (k)
            0:       return LOWER_A;
            1:       return LOWER_A + 1;
            2:       return UPPER_A;
            3:       return UPPER_A + 1;
            4:       return STAR_CHAR;
            default: return ANY_CHAR;
        endcase
    endfunction

    // source bytes: mostly the small set so segments line up, sometimes any nonzero
    function automatic logic [CHAR_W-1:0] random_char();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) begin
            return sample_char(k);
        end
        return CHAR_W'($urandom_range(1, 255));
    endfunction

    function automatic logic [CHAR_W-1:0] random_pattern_char();
        int k;
        k = $urandom_range(0, 19);
        if (k < 10) begin
            return sample_char(k % 4);
        end
        if (k < 14) begin
            return STAR_CHAR;
        end
        if (k < 18) begin
            return ANY_CHAR;
        end
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [PAT_W-1:0] pack_text(input string s);
        logic [PAT_W-1:0] r;
        r = '0;
        for (int i = 0; i < s.len() && i < 32; i++) begin
            r[i*CHAR_W +: CHAR_W] = s[i];
        end
        return r;
    endfunction

    function automatic t_bytes to_bytes(input string s);
        t_bytes r;
        for (int i = 0; i < s.len(); i++) begin
            r.push_back(s[i]);
        end
        return r;
    endfunction

    // expand the loaded pattern into a string it accepts, unless it holds a zero byte
    function automatic t_bytes matching_string();
        t_bytes            r;
        logic [CHAR_W-1:0] p;
        for (int i = 0; i < cur_len; i++) begin
            p = cur_pattern[i*CHAR_W +: CHAR_W];
            if (p == STAR_CHAR) begin
                repeat ($urandom_range(0, 3)) r.push_back(random_char());
            end else if (p == ANY_CHAR) begin
                r.push_back(random_char());
            end else begin
                // with folding on, either case of a letter is fine
                if (cur_fold && $urandom_range(0, 1) == 1 &&
                    ((p >= UPPER_A && p <= UPPER_Z) || (p >= LOWER_A && p <= LOWER_Z))) begin
                    p = p ^ CASE_BIT;
                end
                r.push_back(p);
            end
        end
        return r;
    endfunction

    // one edit: change, drop or add a byte
    function automatic t_bytes mutate(input t_bytes s);
        t_bytes r;
        int     pos;
        r = s;
        case ($urandom_range(0, 2))
            0: begin
                if (r.size() > 0) begin
                    r[$urandom_range(0, r.size() - 1)] = random_char();
                end
            end
            1: begin
                if (r.size() > 0) begin
                    r.delete($urandom_range(0, r.size() - 1));
                end
            end
            default: begin
                pos = $urandom_range(0, r.size());
                r.insert(pos, random_char());
            end
        endcase
        return r;
    endfunction

    // zero bytes in between consume nothing; a trailing one carries last
    function automatic t_bytes sprinkle_zeros(input t_bytes s);
        t_bytes r;
        foreach (s[i]) begin
            if ($urandom_range(0, 15) == 0) begin
                r.push_back(NO_CHAR);
            end
            r.push_back(s[i]);
        end
        if ($urandom_range(0, 7) == 0) begin
            r.push_back(NO_CHAR);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------------

    // valid is only lowered when a gap follows, so back-to-back words keep it high
    task automatic send_word(input logic [CHAR_W-1:0] c, input logic is_last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            src_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        src_ch.valid       <= 1'b1;
        src_ch.source_char <= c;
        src_ch.last        <= is_last;
        do @(posedge i_clk); while (!src_ch.ready);
    endtask

    // an empty string is a lone zero byte with last set
    task automatic send_string(input t_bytes s);
        if (s.size() == 0) begin
            send_word(NO_CHAR, 1'b1);
        end else begin
            foreach (s[i]) begin
                send_word(s[i], i == s.size() - 1);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain: no word offered, every matched word back, then a few spare cycles
    task automatic quiesce();
        src_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_pattern(input logic [PAT_W-1:0] bytes, input logic [LEN_W-1:0] len_code,
                                input logic fold_on);
        write_reg(REG_PATTERN_LENGTH, WORD_W'(len_code));
        write_reg(REG_BYTES_LOW,    bytes[0*WORD_W +: WORD_W]);
        write_reg(REG_BYTES_SECOND, bytes[1*WORD_W +: WORD_W]);
        write_reg(REG_BYTES_THIRD,  bytes[2*WORD_W +: WORD_W]);
        write_reg(REG_BYTES_HIGH,   bytes[3*WORD_W +: WORD_W]);
        write_reg(REG_CASE_INSENSITIVE, WORD_W'(fold_on));
        cur_pattern = bytes;
        cur_len     = (int'(len_code) > 32) ? 32 : int'(len_code);
        cur_fold    = fold_on;
    endtask

    // random pattern: mostly short, sometimes empty, full or over-long length
    task automatic load_random_pattern();
        logic [LEN_W-1:0] len_code;
        logic [PAT_W-1:0] bytes;
        int               used;
        case ($urandom_range(0, 15))
            0:       len_code = '0;
            1:       len_code = LEN_W'(32);
            2:       len_code = LEN_W'($urandom_range(33, 63));
            default: len_code = LEN_W'($urandom_range(1, 10));
        endcase
        used = (int'(len_code) > 32) ? 32 : int'(len_code);
        for (int i = 0; i < 32; i++) begin
            // bytes past the length are junk that must not matter
            bytes[i*CHAR_W +: CHAR_W] = (i < used) ? random_pattern_char()
                                                   : CHAR_W'($urandom_range(0, 255));
        end
        load_pattern(bytes, len_code, 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, plus a long hold-off when asked
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (long_holds_done < long_holds_asked) begin
                // sender keeps going, the block fills and blocks the next last word
                res_ch.ready <= 1'b0;
                for (int k = 0; k < LONG_HOLD_CYCLES; k++) begin
                    @(posedge i_clk);
                end
                long_holds_done++;
            end else begin
                gap = no_gaps ? 0 : $urandom_range(0, 3);
                if (gap > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any word moving on any channel
    // ------------------------------------------------------------------------
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((src_ch.valid && src_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [PAT_W-1:0] bytes;
        t_bytes           s;
        int               sent;
        int               set_no;

        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        src_ch.valid       = 1'b0;
        src_ch.source_char = NO_CHAR;
        src_ch.last        = 1'b0;
        cur_pattern        = '0;
        cur_len            = 0;
        cur_fold           = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pattern out of reset: only the empty string matches
        send_string(to_bytes(""));
        send_string(to_bytes("a"));
        quiesce();

        // any-char and trailing star, exact compare
        load_pattern(pack_text("a?c*"), LEN_W'(4), 1'b0);
        send_string(to_bytes("abcz"));
        send_string(to_bytes("ABC"));
        quiesce();

        // folding on: zero byte inside the string, then a zero byte ending it
        load_pattern(pack_text("Ab*"), LEN_W'(3), 1'b1);
        send_string({LOWER_A, NO_CHAR, UPPER_A + 1});
        send_string({UPPER_A, LOWER_A + 1, NO_CHAR});
        quiesce();

        // length past the maximum saturates: 31 stars and one any-char
        bytes = {32{STAR_CHAR}};
        bytes[31*CHAR_W +: CHAR_W] = ANY_CHAR;
        load_pattern(bytes, LEN_W'(63), 1'b0);
        send_string({8'hFF});
        send_string(to_bytes(""));
        quiesce();

        // unmapped indexes change nothing; a zero pattern byte never matches
        load_pattern('0, LEN_W'(1), 1'b0);
        write_reg(REG_UNMAPPED_LO, '1);
        write_reg(REG_UNMAPPED_HI, '1);
        send_string(to_bytes(""));
        send_string({8'h80});
        send_string({8'h01});
        quiesce();

        // random sets of strings, a new pattern for each set
        sent   = 0;
        set_no = 0;
        while (sent < RANDOM_WORDS) begin
            load_random_pattern();
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                          {$urandom, $urandom});
            end
            no_gaps = (set_no % 5 == 3);
            if (set_no == 2 || set_no == 7) begin
                long_holds_asked++;
            end
            for (int k = 0; k < STRINGS_PER_SET; k++) begin
                case ($urandom_range(0, 15))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9: s = matching_string();
                    10, 11, 12:                   s = mutate(matching_string());
                    default: begin
                        s.delete();
                        repeat ($urandom_range(0, 12)) s.push_back(random_char());
                    end
                endcase
                s = sprinkle_zeros(s);
                send_string(s);
                sent += (s.size() == 0) ? 1 : s.size();
            end
            quiesce();
            set_no++;
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
